// ----- sv/aes128_pkg.sv -----
// Package for the AES-128 block encryption unit.
// Holds the S-box, round constants, the state type and the round functions.
// No dependencies.
`default_nettype none

package aes128_pkg;

  localparam int unsigned Rounds   = 10;
  localparam int unsigned BlockW   = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned RoundCntW = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  // Payload that travels down the pipeline with each valid bit.
  typedef struct packed {
    logic   last;
    block_t state;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants, one per generated round key.
  localparam logic [7:0] RCON [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows; byte i sits in bits 127-8i downward.
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    int     r;
    int     c;
    t = '0;
    for (c = 0; c < 4; c++) begin
      for (r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = SBOX[s[BlockW-1-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return t;
  endfunction

  // MixColumns over the four independent columns.
  function automatic block_t mix_columns(input block_t s);
    block_t     t;
    logic [7:0] a0, a1, a2, a3;
    int         c;
    t = '0;
    for (c = 0; c < 4; c++) begin
      a0 = s[BlockW-1-32*c -: 8];
      a1 = s[BlockW-9-32*c -: 8];
      a2 = s[BlockW-17-32*c -: 8];
      a3 = s[BlockW-25-32*c -: 8];
      t[BlockW-1-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BlockW-9-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BlockW-17-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BlockW-25-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- sv/aes128_ifs.sv -----
// Valid/ready channel interfaces for plaintext in and ciphertext out.
// Depends on nothing.
`default_nettype none

interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  logic        last_block;
  modport source (output valid, plain_high, plain_low, last_block, input ready);
  modport sink   (input valid, plain_high, plain_low, last_block, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        last_out;
  modport source (output valid, cipher_high, cipher_low, last_out, input ready);
  modport sink   (input valid, cipher_high, cipher_low, last_out, output ready);
endinterface

`default_nettype wire

// ----- sv/aes128_key_exp.sv -----
// Key registers and round key expansion, one round key per cycle.
// Depends on aes128_pkg.
`default_nettype none

module aes128_key_exp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [aes128_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [aes128_pkg::HalfW-1:0]      cfg_data,
  output logic                                   busy,
  output aes128_pkg::block_t                     rkey_sched [aes128_pkg::Rounds+1]
);

  logic [aes128_pkg::HalfW-1:0]     key_high;
  logic [aes128_pkg::HalfW-1:0]     key_low;
  logic [aes128_pkg::RoundCntW-1:0] cnt;
  aes128_pkg::block_t               cur;
  aes128_pkg::block_t               src;
  aes128_pkg::block_t               cur_next;
  logic [31:0]                      rot;
  logic [31:0]                      tw;
  logic [31:0]                      n0, n1, n2, n3;

  // The first step starts from the key itself, later steps from the last key.
  assign src = (cnt == '0) ? {key_high, key_low} : cur;

  // RotWord, SubWord and round constant on the last word, then the XOR chain.
  always_comb begin
    rot = {src[23:0], src[31:24]};
    tw  = {aes128_pkg::SBOX[rot[31:24]] ^ aes128_pkg::RCON[cnt],
           aes128_pkg::SBOX[rot[23:16]],
           aes128_pkg::SBOX[rot[15:8]],
           aes128_pkg::SBOX[rot[7:0]]};
    n0 = src[127:96] ^ tw;
    n1 = src[95:64] ^ n0;
    n2 = src[63:32] ^ n1;
    n3 = src[31:0] ^ n2;
    cur_next = {n0, n1, n2, n3};
  end

  // Key writes restart the expansion; reset expands the all-zero key.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      busy     <= 1'b1;
      cnt      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aes128_pkg::RegKeyHigh) begin
        key_high <= cfg_data;
      end else begin
        key_low <= cfg_data;
      end
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      rkey_sched[cnt] <= src;
      if (cnt == aes128_pkg::RoundCntW'(aes128_pkg::Rounds)) begin
        busy <= 1'b0;
      end else begin
        cur <= cur_next;
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/aes128_round.sv -----
// One registered AES round: SubBytes, ShiftRows, MixColumns (left out when FINAL is set), AddRoundKey.
// Depends on aes128_pkg.
`default_nettype none

module aes128_round #(
  parameter bit FINAL = 1'b0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire aes128_pkg::stage_t  up,
  input  wire aes128_pkg::block_t  rkey,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output aes128_pkg::stage_t       dn
);

  aes128_pkg::block_t ss;
  aes128_pkg::block_t mixed;

  // The final round leaves out MixColumns.
  assign ss    = aes128_pkg::sub_shift(up.state);
  assign mixed = FINAL ? ss : aes128_pkg::mix_columns(ss);

  // The stage takes a new item when empty or when its content moves on.
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn.state <= mixed ^ rkey;
      dn.last  <= up.last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/aes128_block_encrypt_unit.sv -----
// Top level of the AES-128 block encryption unit: input stage, ten rounds.
// Depends on aes128_pkg, aes128_ifs, aes128_key_exp and aes128_round.
//
//   channel  | direction | payload                               | transfer
//   in       | sink      | plain_high, plain_low, last_block     | valid & ready
//   out      | source    | cipher_high, cipher_low, last_out     | valid & ready
//   cfg      | write     | cfg_index (0 key_high, 1 key_low)     | cfg_we
//
// One block per cycle enters while in.ready is high; each block passes through the
// AddRoundKey stage and then one register per round. Each stage holds its item
// while the next one cannot take it. After reset or any key write the key expander
// fills the round keys, and in.ready stays low until it is done.
`default_nettype none

module aes128_block_encrypt_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [aes128_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [aes128_pkg::HalfW-1:0]   cfg_data,
  aes128_in_if.sink                           in,
  aes128_out_if.source                        out
);

  localparam int unsigned N = aes128_pkg::Rounds;

  aes128_pkg::block_t rkey_sched [N+1];
  logic               busy;
  logic               v   [N+1];
  logic               rdy [N+2];
  aes128_pkg::stage_t st  [N+1];

  aes128_key_exp u_key_exp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .rkey_sched (rkey_sched)
  );

  // Input stage with the initial AddRoundKey.
  assign rdy[0]   = !v[0] || rdy[1];
  assign in.ready = rdy[0] && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in.valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      st[0].state <= {in.plain_high, in.plain_low} ^ rkey_sched[0];
      st[0].last  <= in.last_block;
    end
  end

  // One registered stage per round.
  for (genvar r = 1; r <= N; r++) begin : g_round
    aes128_round #(.FINAL(r == N)) u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (v[r-1]),
      .up_ready (rdy[r]),
      .up       (st[r-1]),
      .rkey     (rkey_sched[r]),
      .dn_valid (v[r]),
      .dn_ready (rdy[r+1]),
      .dn       (st[r])
    );
  end

  assign rdy[N+1]        = out.ready;
  assign out.valid       = v[N];
  assign out.cipher_high = st[N].state[aes128_pkg::BlockW-1 -: aes128_pkg::HalfW];
  assign out.cipher_low  = st[N].state[aes128_pkg::HalfW-1:0];
  assign out.last_out    = st[N].last;

endmodule

`default_nettype wire

// ----- sv/aes128_checker.sv -----
// Port-level checks for the AES-128 block encryption unit, bound to the top.
// Depends on aes128_block_encrypt_unit.
`default_nettype none

module aes128_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Round keys are rebuilt after reset, so no block is taken right away.
  a_rst_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("block taken during key expansion after reset");

  // A key write starts a new expansion that blocks input.
  a_cfg_busy: assert property (@(posedge clk) cfg_we |=> !in_ready)
    else $error("block taken during key expansion after a key write");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind aes128_block_encrypt_unit aes128_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .in_ready  (in.ready),
  .out_valid (out.valid),
  .out_ready (out.ready)
);

`default_nettype wire
